// File: hdl/hsl_hwb_to_rgb_assert.svh
// Assertion macros for the HSL/HWB to RGB converter.
// Expect clk and rst_n in the including scope; no other dependencies.
`ifndef HSL_HWB_TO_RGB_ASSERT_SVH
`define HSL_HWB_TO_RGB_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define HSL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define HSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/hslhwb_pkg.sv
// Constants, types and helper functions for the HSL/HWB to RGB converter.
// Stand-alone; used by hsl_hwb_to_rgb.
package hslhwb_pkg;

  typedef enum logic {
    MODE_HSL = 1'b0,
    MODE_HWB = 1'b1
  } mode_t;

  localparam logic [16:0] HUE_FULL    = 17'd92160;      // 360 degrees
  localparam logic [24:0] HUE_BIAS    = 25'd8478720;    // 92 turns, keeps hue positive
  localparam logic [10:0] HUE_RECIP   = 11'd1456;       // floor(2^16 / 45)
  localparam logic [13:0] HUE_BLK     = 14'd45;         // turn in 2048-unit blocks
  localparam logic [14:0] PCT_FULL    = 15'd25600;      // 100 percent
  localparam logic [13:0] SEXT_UNIT   = 14'd7680;       // 30 degrees
  localparam logic [15:0] CH_FULL     = 16'd65280;      // 255.0
  localparam logic [17:0] GRAY_SCALE  = 18'd130560;     // 2 * CH_FULL
  localparam logic [27:0] LPU         = 28'd196608000;  // PCT_FULL * SEXT_UNIT
  localparam logic [14:0] WHITE_SCALE = 15'd15360;      // 2 * SEXT_UNIT
  localparam logic [47:0] HSL_RND     = 48'd1310720000; // 2^21 * 625
  localparam logic [34:0] HWB_RND     = 35'd102400;     // 2^12 * 25
  localparam logic [31:0] K_HSL       = 32'd109951162;  // floor(2^36 / 625)
  localparam logic [31:0] K_HWB       = 32'd2748779069; // floor(2^36 / 25)
  localparam logic [9:0]  D_HSL       = 10'd625;
  localparam logic [9:0]  D_HWB       = 10'd25;
  localparam int          DIV_BITS    = 4;              // quotient bits per stage

  typedef struct packed {
    logic [16:0] rem;
    logic [15:0] nlo;
    logic [15:0] quo;
  } div_t;

  function automatic logic [14:0] clamp_pct(input logic signed [23:0] p);
    logic [14:0] r;
    if (p < 24'sd0) r = '0;
    else if (p > 24'sd25600) r = PCT_FULL;
    else r = p[14:0];
    return r;
  endfunction

  // Channel offset n * 30 degrees: red 0, green 8, blue 4.
  function automatic logic [17:0] tri_offset(input int k);
    logic [17:0] r;
    unique case (k)
      0:       r = 18'd0;
      1:       r = 18'd61440;
      default: r = 18'd30720;
    endcase
    return r;
  endfunction

  // Clamped triangle term, scaled by SEXT_UNIT.
  function automatic logic signed [13:0] tri_term(input logic [16:0] h, input int k);
    logic [17:0]        x;
    logic signed [18:0] a;
    logic signed [18:0] b;
    logic signed [18:0] m;
    x = 18'(h) + tri_offset(k);
    if (x >= 18'(HUE_FULL)) x = x - 18'(HUE_FULL);
    a = $signed({1'b0, x}) - 19'sd23040;
    b = 19'sd69120 - $signed({1'b0, x});
    m = (a < b) ? a : b;
    if (m > 19'sd7680) m = 19'sd7680;
    if (m < -19'sd7680) m = -19'sd7680;
    return 14'(m);
  endfunction

  // A few steps of restoring division.
  function automatic div_t div_stage(input div_t a, input logic [16:0] d);
    div_t        r;
    logic [17:0] t;
    r = a;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r.rem, r.nlo[15]};
      r.nlo = {r.nlo[14:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
        r.quo = {r.quo[14:0], 1'b1};
      end else begin
        r.quo = {r.quo[14:0], 1'b0};
      end
      r.rem = t[16:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/hsl_hwb_to_rgb.sv
// HSL/HWB to RGB colour converter, seven-stage pipeline, CSS Color 4 formulas.
// Depends on hslhwb_pkg and hsl_hwb_to_rgb_assert.svh.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+-----------
//   input   | in_valid in_stall in_cmd in_hue         | word in
//           | in_first_pct in_second_pct              |
//   result  | out_valid out_stall out_red out_green   | word out
//           | out_blue                                |
//
// One word enters per clock while in_stall is low. Each result passes through
// the seven register stages (hue wrap, triangle terms, the per-channel
// multipliers, rounding by reciprocal and the gray divider, which
// resolves four quotient bits per stage) before it shows on the outputs.
// Reset clears only the stage valid bits; data registers load freely.
// A stall on the result side holds the last stage; earlier stages keep
// moving into empty slots, so new words are still taken until every stage
// is full.
module hsl_hwb_to_rgb (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic signed [23:0] in_hue,
  input  logic signed [23:0] in_first_pct,
  input  logic signed [23:0] in_second_pct,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_red,
  output logic [15:0]        out_green,
  output logic [15:0]        out_blue
);

  // Stage valid bits and per-stage load enables.
  logic [7:1] v_r;
  logic [7:1] en;

  always_comb begin
    en[7] = !v_r[7] || !out_stall;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = v_r[7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: clamp percentages, bias the hue positive, estimate its turn
  // count, form s*min(l,1-l) and the gray divider operands.
  // ---------------------------------------------------------------------
  logic [24:0] hu_nxt;
  logic [24:0] hq_prod;
  logic [14:0] s_nxt, l_nxt, mn_nxt;
  logic [15:0] wb_nxt;
  logic [31:0] gn_nxt;

  always_comb begin
    hu_nxt  = {in_hue[23], in_hue} + hslhwb_pkg::HUE_BIAS;
    hq_prod = 25'(hu_nxt[24:11]) * 25'(hslhwb_pkg::HUE_RECIP);
    s_nxt   = hslhwb_pkg::clamp_pct(in_first_pct);
    l_nxt   = hslhwb_pkg::clamp_pct(in_second_pct);
    mn_nxt  = (l_nxt < hslhwb_pkg::PCT_FULL - l_nxt) ? l_nxt
                                                     : hslhwb_pkg::PCT_FULL - l_nxt;
    wb_nxt  = 16'(s_nxt) + 16'(l_nxt);
    gn_nxt  = 32'(s_nxt) * 32'(hslhwb_pkg::GRAY_SCALE) + 32'(wb_nxt);
  end

  hslhwb_pkg::mode_t mode1_r;
  logic [10:0]       low1_r;
  logic [13:0]       hv1_r;
  logic [7:0]        hq1_r;
  logic [14:0]       s1_r, l1_r;
  logic [28:0]       smn1_r;
  logic [15:0]       wb1_r;
  logic              gray1_r;
  hslhwb_pkg::div_t  div1_r;
  logic [16:0]       dd1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mode1_r  <= hslhwb_pkg::mode_t'(in_cmd);
      low1_r   <= hu_nxt[10:0];
      hv1_r    <= hu_nxt[24:11];
      hq1_r    <= hq_prod[23:16];
      s1_r     <= s_nxt;
      l1_r     <= l_nxt;
      smn1_r   <= 29'(s_nxt) * 29'(mn_nxt);
      wb1_r    <= wb_nxt;
      gray1_r  <= wb_nxt >= 16'(hslhwb_pkg::PCT_FULL);
      div1_r   <= '{rem: {1'b0, gn_nxt[31:16]}, nlo: gn_nxt[15:0], quo: '0};
      dd1_r    <= {wb_nxt, 1'b0};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: finish the hue wrap (one correction), remaining percentage for
  // HWB, first divider bits.
  // ---------------------------------------------------------------------
  logic [13:0] hr_nxt;
  logic [13:0] hr6_nxt;

  always_comb begin
    hr_nxt  = hv1_r - 14'(hq1_r) * hslhwb_pkg::HUE_BLK;
    hr6_nxt = (hr_nxt >= hslhwb_pkg::HUE_BLK) ? hr_nxt - hslhwb_pkg::HUE_BLK : hr_nxt;
  end

  hslhwb_pkg::mode_t mode2_r;
  logic [16:0]       h2_r;
  logic [14:0]       s2_r, l2_r, pmw2_r;
  logic [28:0]       smn2_r;
  logic              gray2_r;
  hslhwb_pkg::div_t  div2_r;
  logic [16:0]       dd2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mode2_r <= mode1_r;
      h2_r    <= {hr6_nxt[5:0], low1_r};
      s2_r    <= s1_r;
      l2_r    <= l1_r;
      pmw2_r  <= hslhwb_pkg::PCT_FULL - wb1_r[14:0];
      smn2_r  <= smn1_r;
      gray2_r <= gray1_r;
      div2_r  <= hslhwb_pkg::div_stage(div1_r, dd1_r);
      dd2_r   <= dd1_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: triangle terms for red, green and blue; l * P * U.
  // ---------------------------------------------------------------------
  hslhwb_pkg::mode_t  mode3_r;
  logic signed [13:0] m3_r [3];
  logic [28:0]        smn3_r;
  logic [14:0]        s3_r, pmw3_r;
  logic [42:0]        lpu3_r;
  logic               gray3_r;
  hslhwb_pkg::div_t   div3_r;
  logic [16:0]        dd3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      mode3_r <= mode2_r;
      for (int k = 0; k < 3; k++) begin
        m3_r[k] <= hslhwb_pkg::tri_term(h2_r, k);
      end
      smn3_r  <= smn2_r;
      s3_r    <= s2_r;
      pmw3_r  <= pmw2_r;
      lpu3_r  <= 43'(l2_r) * 43'(hslhwb_pkg::LPU);
      gray3_r <= gray2_r;
      div3_r  <= hslhwb_pkg::div_stage(div2_r, dd2_r);
      dd3_r   <= dd2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: one multiplier per channel for each mode.
  // ---------------------------------------------------------------------
  hslhwb_pkg::mode_t  mode4_r;
  logic signed [43:0] ps4_r [3];
  logic [29:0]        pw4_r [3];
  logic [42:0]        lpu4_r;
  logic [14:0]        s4_r;
  logic               gray4_r;
  hslhwb_pkg::div_t   div4_r;
  logic [16:0]        dd4_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      mode4_r <= mode3_r;
      for (int k = 0; k < 3; k++) begin
        ps4_r[k] <= 44'($signed({1'b0, smn3_r})) * 44'(m3_r[k]);
        pw4_r[k] <= 30'(14'(hslhwb_pkg::SEXT_UNIT - $unsigned(m3_r[k]))) * 30'(pmw3_r);
      end
      lpu4_r  <= lpu3_r;
      s4_r    <= s3_r;
      gray4_r <= gray3_r;
      div4_r  <= hslhwb_pkg::div_stage(div3_r, dd3_r);
      dd4_r   <= dd3_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: numerators, clamp at zero, add the half and drop the
  // power-of-two part of the divisor.
  // ---------------------------------------------------------------------
  logic [25:0] y_nxt [3];

  always_comb begin
    logic signed [43:0] nh;
    logic [42:0]        nhc;
    logic [47:0]        th;
    logic [29:0]        nw;
    logic [34:0]        tw;
    for (int k = 0; k < 3; k++) begin
      nh  = $signed({1'b0, lpu4_r}) - ps4_r[k];
      nhc = (nh < 44'sd0) ? '0 : nh[42:0];
      th  = {nhc, 5'b0} + {4'b0, nhc, 1'b0} + hslhwb_pkg::HSL_RND;
      nw  = pw4_r[k] + 30'(s4_r) * 30'(hslhwb_pkg::WHITE_SCALE);
      tw  = 35'(nw) * 35'd34 + hslhwb_pkg::HWB_RND;
      y_nxt[k] = (mode4_r == hslhwb_pkg::MODE_HSL) ? th[47:22] : 26'(tw[34:13]);
    end
  end

  hslhwb_pkg::mode_t mode5_r;
  logic [25:0]       y5_r [3];
  logic              gray5_r;
  logic [15:0]       quo5_r;
  hslhwb_pkg::div_t  div5_nxt;

  assign div5_nxt = hslhwb_pkg::div_stage(div4_r, dd4_r);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      mode5_r <= mode4_r;
      y5_r    <= y_nxt;
      gray5_r <= gray4_r;
      quo5_r  <= div5_nxt.quo;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: divide by 625 or 25 through a reciprocal; may come out low by one.
  // ---------------------------------------------------------------------
  logic [31:0] k_sel;
  assign k_sel = (mode5_r == hslhwb_pkg::MODE_HSL) ? hslhwb_pkg::K_HSL : hslhwb_pkg::K_HWB;

  hslhwb_pkg::mode_t mode6_r;
  logic [25:0]       y6_r [3];
  logic [16:0]       q6_r [3];
  logic              gray6_r;
  logic [15:0]       quo6_r;

  always_ff @(posedge clk) begin
    logic [57:0] prod;
    if (en[6]) begin
      mode6_r <= mode5_r;
      for (int k = 0; k < 3; k++) begin
        prod     = 58'(y5_r[k]) * 58'(k_sel);
        q6_r[k] <= prod[52:36];
      end
      y6_r    <= y5_r;
      gray6_r <= gray5_r;
      quo6_r  <= quo5_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: correct the quotient, saturate, pick gray for HWB overflow.
  // ---------------------------------------------------------------------
  logic [9:0]  d_sel;
  logic        gray_sel;
  logic [15:0] ch_nxt [3];

  assign d_sel    = (mode6_r == hslhwb_pkg::MODE_HSL) ? hslhwb_pkg::D_HSL : hslhwb_pkg::D_HWB;
  assign gray_sel = (mode6_r == hslhwb_pkg::MODE_HWB) && gray6_r;

  always_comb begin
    logic [26:0] r;
    logic [17:0] qf;
    for (int k = 0; k < 3; k++) begin
      r  = 27'(y6_r[k]) - 27'(q6_r[k]) * 27'(d_sel);
      qf = 18'(q6_r[k]) + ((r >= 27'(d_sel)) ? 18'd1 : 18'd0);
      if (gray_sel) ch_nxt[k] = quo6_r;
      else if (qf > 18'(hslhwb_pkg::CH_FULL)) ch_nxt[k] = hslhwb_pkg::CH_FULL;
      else ch_nxt[k] = qf[15:0];
    end
  end

  logic [15:0] red_r, green_r, blue_r;
  logic        gray7_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      red_r   <= ch_nxt[0];
      green_r <= ch_nxt[1];
      blue_r  <= ch_nxt[2];
      gray7_r <= gray_sel;
    end
  end

  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

`include "hsl_hwb_to_rgb_assert.svh"

  `HSL_ASSERT_NOW(a_out_range, out_valid, (out_red <= hslhwb_pkg::CH_FULL) && (out_green <= hslhwb_pkg::CH_FULL) && (out_blue <= hslhwb_pkg::CH_FULL), "channel above 255")
  `HSL_ASSERT_NOW(a_hue_wrap, v_r[2], h2_r < hslhwb_pkg::HUE_FULL, "hue not wrapped below 360")
  `HSL_ASSERT_NOW(a_gray_equal, out_valid && gray7_r, (out_red == out_green) && (out_green == out_blue), "gray result channels differ")
  `HSL_ASSERT_NOW(a_stall_full, in_stall, &v_r, "input stalled with a free stage")
  `HSL_ASSERT_NEXT(a_advance, v_r[6] && en[6], v_r[7], "word lost entering output stage")

endmodule

// File: test/hsl_hwb_to_rgb_chk.sv
// Checker for the HSL/HWB to RGB converter: watches both channels,
// predicts each colour and compares it. Depends on hslhwb_pkg.
`timescale 1ns / 1ps
module hsl_hwb_to_rgb_chk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_cmd,
  input  logic signed [23:0] in_hue,
  input  logic signed [23:0] in_first_pct,
  input  logic signed [23:0] in_second_pct,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        out_red,
  input  logic [15:0]        out_green,
  input  logic [15:0]        out_blue,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } rgb_t;

  rgb_t colour_q[$];

  function automatic longint pct_lim(input logic signed [23:0] p);
    longint v;
    v = p;
    if (v < 0) v = 0;
    if (v > 25600) v = 25600;
    return v;
  endfunction

  function automatic longint tri_val(input longint n, input longint h);
    longint x, a, b, m;
    x = n * 7680 + h;
    if (x >= 92160) x -= 92160;
    a = x - 23040;
    b = 69120 - x;
    m = (a < b) ? a : b;
    if (m > 7680) m = 7680;
    if (m < -7680) m = -7680;
    return m;
  endfunction

  function automatic logic [15:0] round_ch(input longint num, input longint den);
    longint r;
    if (num < 0) num = 0;
    r = (num * 65280 + den / 2) / den;
    if (r > 65280) r = 65280;
    return r[15:0];
  endfunction

  function automatic rgb_t convert_colour(input logic mode, input logic signed [23:0] hue,
                                          input logic signed [23:0] p1_in,
                                          input logic signed [23:0] p2_in);
    longint h, p1, p2, mn, wb, m;
    longint offs[3];
    logic [15:0] ch[3];
    rgb_t r;
    offs = '{0, 8, 4};
    h = longint'(hue) % 92160;
    if (h < 0) h += 92160;
    p1 = pct_lim(p1_in);
    p2 = pct_lim(p2_in);
    wb = p1 + p2;
    if (mode == hslhwb_pkg::MODE_HSL) begin
      mn = (p2 < 25600 - p2) ? p2 : 25600 - p2;
      for (int k = 0; k < 3; k++) begin
        m = tri_val(offs[k], h);
        ch[k] = round_ch(p2 * 25600 * 7680 - p1 * mn * m, longint'(25600) * 25600 * 7680);
      end
    end else if (wb >= 25600) begin
      for (int k = 0; k < 3; k++) ch[k] = round_ch(p1, wb);
    end else begin
      for (int k = 0; k < 3; k++) begin
        m = tri_val(offs[k], h);
        ch[k] = round_ch((7680 - m) * (25600 - wb) + p1 * 15360, longint'(2) * 7680 * 25600);
      end
    end
    r.red = ch[0];
    r.green = ch[1];
    r.blue = ch[2];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    rgb_t want;
    if (!rst_n) begin
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall)
        colour_q.push_back(convert_colour(in_cmd, in_hue, in_first_pct, in_second_pct));
      if (out_valid && !out_stall) begin
        if (colour_q.size() == 0) begin
          report_mismatch("unexpected word", out_red, 16'd0);
        end else begin
          want = colour_q.pop_front();
          if (out_red !== want.red) report_mismatch("red", out_red, want.red);
          if (out_green !== want.green) report_mismatch("green", out_green, want.green);
          if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
        end
      end
    end
    pending = colour_q.size();
  end

endmodule

// File: test/tb_hsl_hwb_to_rgb.sv
// Top of the HSL/HWB to RGB converter testbench: clock, reset, stimulus, verdict.
// Depends on hslhwb_pkg, hsl_hwb_to_rgb and hsl_hwb_to_rgb_chk.
`timescale 1ns / 1ps
module tb_hsl_hwb_to_rgb;

  localparam int RANDOM_WORDS = 1750;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_cmd;
  logic signed [23:0] in_hue;
  logic signed [23:0] in_first_pct;
  logic signed [23:0] in_second_pct;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        out_red;
  logic [15:0]        out_green;
  logic [15:0]        out_blue;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  int                 stall_mode = 0;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hsl_hwb_to_rgb i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_hue(in_hue),
    .in_first_pct(in_first_pct), .in_second_pct(in_second_pct),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
  );

  hsl_hwb_to_rgb_chk i_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_hue(in_hue),
    .in_first_pct(in_first_pct), .in_second_pct(in_second_pct),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .fail_count(fail_count), .pending(pending)
  );

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver stall pattern: switch at random between free flow, light, heavy
  // and periodic stalling so gaps land on every stage.
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cycle_count % 5) < 2;
    endcase
  end

  // Percentage picker: mostly in range, sometimes at or beyond the edges.
  function automatic logic signed [23:0] pick_pct();
    case ($urandom_range(0, 9))
      0: return 24'($urandom);
      1: return 24'sd0;
      2: return 24'sd25600;
      3: return 24'sd25600 + 24'($urandom_range(1, 300));
      4: return -24'($urandom_range(1, 300));
      default: return 24'($urandom_range(0, 25600));
    endcase
  endfunction

  function automatic logic signed [23:0] pick_hue();
    case ($urandom_range(0, 7))
      0: return 24'($urandom);
      1: return 24'(7680 * $urandom_range(0, 12));
      2: return -24'($urandom_range(0, 200000));
      default: return 24'($urandom_range(0, 92159));
    endcase
  endfunction

  // Present one word and hold it until taken. Valid stays high into the
  // next word; only the caller drops it during gaps.
  task automatic send_colour(input logic mode, input logic signed [23:0] hue,
                             input logic signed [23:0] p1, input logic signed [23:0] p2);
    in_valid      <= 1'b1;
    in_cmd        <= mode;
    in_hue        <= hue;
    in_first_pct  <= p1;
    in_second_pct <= p2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  initial begin
    int burst;
    int sent;
    int wait_cycles;
    logic signed [23:0] w;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = hslhwb_pkg::MODE_HSL;
    in_hue        = '0;
    in_first_pct  = '0;
    in_second_pct = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, both modes, hue wrap, clamping, HWB gray.
    send_colour(hslhwb_pkg::MODE_HSL, 24'sd0, 24'sd25600, 24'sd12800);
    send_colour(hslhwb_pkg::MODE_HSL, 24'sd30720, 24'sd25600, 24'sd12800);
    send_colour(hslhwb_pkg::MODE_HSL, 24'sd61440, 24'sd25600, 24'sd12800);
    send_colour(hslhwb_pkg::MODE_HSL, -24'sd7680, 24'sd25600, 24'sd12800);
    send_colour(hslhwb_pkg::MODE_HSL, 24'sd92160, 24'sd12800, 24'sd6400);
    send_colour(hslhwb_pkg::MODE_HSL, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_colour(hslhwb_pkg::MODE_HSL, 24'h800000, 24'h800000, 24'h800000);
    send_colour(hslhwb_pkg::MODE_HSL, 24'hFFFFFF, 24'sd25600, 24'sd25600);
    send_colour(hslhwb_pkg::MODE_HSL, 24'sd100, 24'sd0, 24'sd0);
    send_colour(hslhwb_pkg::MODE_HSL, 24'sd46080, 24'sd30000, 24'sd19200);
    send_colour(hslhwb_pkg::MODE_HWB, 24'sd0, 24'sd0, 24'sd0);
    send_colour(hslhwb_pkg::MODE_HWB, 24'sd15360, 24'sd6400, 24'sd6400);
    send_colour(hslhwb_pkg::MODE_HWB, 24'sd0, 24'sd12800, 24'sd12800);
    send_colour(hslhwb_pkg::MODE_HWB, 24'sd0, 24'sd12801, 24'sd12800);
    send_colour(hslhwb_pkg::MODE_HWB, 24'sd0, 24'sd25600, 24'sd25600);
    send_colour(hslhwb_pkg::MODE_HWB, 24'h7FFFFF, 24'h7FFFFF, 24'h800000);
    send_colour(hslhwb_pkg::MODE_HWB, 24'h800000, 24'h800000, 24'h7FFFFF);
    send_colour(hslhwb_pkg::MODE_HWB, -24'sd92161, 24'sd1000, 24'sd30000);
    send_colour(hslhwb_pkg::MODE_HWB, 24'sd69120, 24'sd0, 24'sd25599);
    send_colour(hslhwb_pkg::MODE_HWB, 24'sd1, 24'sd8533, 24'sd17067);

    // Random bursts with random gaps; some bursts run back to back.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst; i++) begin
        if ($urandom_range(0, 1)) begin
          // Bias HWB towards both sides of the gray boundary.
          w = pick_pct();
          send_colour(hslhwb_pkg::MODE_HWB, pick_hue(), w,
                      ($urandom_range(0, 3) == 0) ? 24'sd25600 - w : pick_pct());
        end else begin
          send_colour(hslhwb_pkg::MODE_HSL, pick_hue(), pick_pct(), pick_pct());
        end
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    // Drain, then give the pipeline a little longer for stray words.
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
